>>> rtl/kmp_pkg.sv
// Shared types and command codes for the streaming KMP matcher.
`default_nettype none

package kmp_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TEXT   = 2'd2;

    localparam int MATCH_END_W = 16;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] symbol;
        logic       end_of_text;
    } kmp_item_t;

    typedef struct packed {
        logic                   found;
        logic [MATCH_END_W-1:0] match_end;
        logic                   status;
        logic                   text_done;
    } kmp_result_t;

endpackage

`default_nettype wire

>>> rtl/kmp_stream_matcher_core.sv
// Streaming KMP matcher top level: sequencer, search state and result register.
// The result register loads as the item leaves S_EXEC, after any failure-chain steps of the walk,
// with each failed comparison of the walk taking a step on the shared store read port.
// A new item is accepted only once the previous one has finished; the walk is amortized short.
// A waiting result does not block acceptance, but the next item cannot finish until it is taken.
// Reset empties the pattern and clears the search state; the stores are not cleared.
`default_nettype none

module kmp_stream_matcher_core #(
    parameter int PATTERN_MAX = 32,
    parameter int INDEX_BITS  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire kmp_pkg::kmp_item_t item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output kmp_pkg::kmp_result_t    result
);

    localparam int PW = $clog2(PATTERN_MAX + 1);
    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int EW = (INDEX_BITS > kmp_pkg::MATCH_END_W) ? INDEX_BITS : kmp_pkg::MATCH_END_W;
    localparam logic [PW-1:0]         MAX_P     = PW'(PATTERN_MAX);
    localparam logic [INDEX_BITS-1:0] IDX_LIMIT = '1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              cmd_reg, cmd_next;
    logic [7:0]              sym_reg, sym_next;
    logic                    eot_reg, eot_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic                    neg_reg, neg_next;
    logic [PW-1:0]           len_reg, len_next;
    logic [PW-1:0]           bp_reg, bp_next;
    logic [PW-1:0]           mp_reg, mp_next;
    logic                    found_reg, found_next;
    logic [INDEX_BITS-1:0]   idx_reg, idx_next;
    logic [INDEX_BITS-1:0]   first_reg, first_next;
    kmp_pkg::kmp_result_t    result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic                    accept;
    logic                    slot_free;
    logic                    empty;
    logic                    full;
    logic                    walk_req;
    logic                    at_end;
    logic                    finish;
    logic                    step;
    logic [PW-1:0]           hit_pos;
    logic [PW-1:0]           new_bp;
    logic [INDEX_BITS-1:0]   idx_inc;
    logic                    done;
    logic                    wr_en;
    logic [7:0]              rd_sym;
    logic [PW-1:0]           rd_fail;

    kmp_store #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_store (
        .clk          (clk),
        .wr_en        (wr_en),
        .wr_pat_addr  (len_reg[AW-1:0]),
        .wr_sym       (sym_reg),
        .wr_fail_addr (PW'(len_reg + 1'b1)),
        .wr_fail_data (new_bp),
        .rd_addr      (pos_next),
        .rd_sym       (rd_sym),
        .rd_fail      (rd_fail)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign slot_free    = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign empty    = (len_reg == '0);
    assign full     = (len_reg >= MAX_P);
    assign walk_req = ((cmd_reg == kmp_pkg::CMD_APPEND) && !full && !empty)
                   || ((cmd_reg == kmp_pkg::CMD_TEXT) && !empty && !found_reg);
    assign at_end   = neg_reg || (pos_reg >= MAX_P) || (rd_sym == sym_reg);
    assign hit_pos  = (neg_reg || (pos_reg >= MAX_P)) ? '0 : PW'(pos_reg + 1'b1);
    assign new_bp   = empty ? '0 : hit_pos;
    assign idx_inc  = (idx_reg == IDX_LIMIT) ? idx_reg : INDEX_BITS'(idx_reg + 1'b1);
    assign finish   = (state_reg == S_EXEC) && (!walk_req || at_end) && slot_free;
    assign step     = (state_reg == S_EXEC) && walk_req && !at_end;
    assign wr_en    = finish && (cmd_reg == kmp_pkg::CMD_APPEND) && !full;

    always_comb
    begin
        logic [EW-1:0] first_ext;

        first_ext         = '0;
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        sym_next          = sym_reg;
        eot_next          = eot_reg;
        pos_next          = pos_reg;
        neg_next          = neg_reg;
        len_next          = len_reg;
        bp_next           = bp_reg;
        mp_next           = mp_reg;
        found_next        = found_reg;
        idx_next          = idx_reg;
        first_next        = first_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        done              = 1'b0;

        if (accept)
        begin
            state_next = S_EXEC;
            cmd_next   = item.command;
            sym_next   = item.symbol;
            eot_next   = item.end_of_text;
            pos_next   = (item.command == kmp_pkg::CMD_APPEND) ? bp_reg : mp_reg;
            neg_next   = 1'b0;
        end
        else if (step)
        begin
            if (pos_reg == '0)
            begin
                neg_next = 1'b1;
            end
            else
            begin
                pos_next = rd_fail;
            end
        end

        result_next.status    = 1'b0;
        result_next.text_done = 1'b0;

        if (finish)
        begin
            state_next = S_IDLE;
            case (cmd_reg)
                kmp_pkg::CMD_CLEAR:
                begin
                    len_next   = '0;
                    bp_next    = '0;
                    mp_next    = '0;
                    found_next = 1'b0;
                    idx_next   = '0;
                    first_next = '0;
                end
                kmp_pkg::CMD_APPEND:
                begin
                    if (full)
                    begin
                        result_next.status = 1'b1;
                    end
                    else
                    begin
                        bp_next    = new_bp;
                        len_next   = PW'(len_reg + 1'b1);
                        mp_next    = '0;
                        found_next = 1'b0;
                        idx_next   = '0;
                        first_next = '0;
                    end
                end
                kmp_pkg::CMD_TEXT:
                begin
                    idx_next = idx_inc;
                    done     = eot_reg;
                    if (walk_req)
                    begin
                        mp_next = hit_pos;
                        if (hit_pos >= len_reg)
                        begin
                            found_next = 1'b1;
                            first_next = idx_inc;
                            mp_next    = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            first_ext             = EW'(first_next);
            result_next.found     = (len_next == '0) || found_next;
            result_next.match_end = (len_next == '0) ? '0
                                  : first_ext[kmp_pkg::MATCH_END_W-1:0];
            result_next.text_done = done;
            result_valid_next     = 1'b1;

            if (done)
            begin
                mp_next    = '0;
                found_next = 1'b0;
                idx_next   = '0;
                first_next = '0;
            end
        end
        else
        begin
            result_next = result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            len_reg          <= '0;
            bp_reg           <= '0;
            mp_reg           <= '0;
            found_reg        <= 1'b0;
            idx_reg          <= '0;
            first_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            bp_reg           <= bp_next;
            mp_reg           <= mp_next;
            found_reg        <= found_next;
            idx_reg          <= idx_next;
            first_reg        <= first_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        sym_reg    <= sym_next;
        eot_reg    <= eot_next;
        pos_reg    <= pos_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

>>> rtl/kmp_store.sv
// Pattern byte store and failure table with registered read ports.
`default_nettype none

module kmp_store #(
    parameter int PATTERN_MAX = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] wr_pat_addr,
    input  wire logic [7:0]                            wr_sym,
    input  wire logic [$clog2(PATTERN_MAX+1)-1:0]      wr_fail_addr,
    input  wire logic [$clog2(PATTERN_MAX+1)-1:0]      wr_fail_data,
    input  wire logic [$clog2(PATTERN_MAX+1)-1:0]      rd_addr,
    output logic      [7:0]                            rd_sym,
    output logic      [$clog2(PATTERN_MAX+1)-1:0]      rd_fail
);

    localparam int PW = $clog2(PATTERN_MAX + 1);
    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0]    pat_mem  [PATTERN_MAX];
    logic [PW-1:0] fail_mem [PATTERN_MAX+1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pat_mem[wr_pat_addr]   <= wr_sym;
            fail_mem[wr_fail_addr] <= wr_fail_data;
        end
        rd_sym  <= pat_mem[rd_addr[AW-1:0]];
        rd_fail <= fail_mem[rd_addr];
    end

endmodule

`default_nettype wire
